// ===== src/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the bitmap first-free allocator
// Field widths, result codes, request kinds and controller/datapath structs.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int CNT_W      = 13;    // count register width
  localparam int IDX_W      = 12;    // block index width
  localparam int STATUS_W   = 2;
  localparam int INDEX_SPAN = 4096;  // span of a 12-bit index

  localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic clr;         // clearing pass, one word per cycle
    logic load_idx;    // latch the free index
    logic scan_init;   // restart the word scan at word 0
    logic scan_step;   // issue next read, evaluate previous word
    logic alloc_wr;    // write back found word, return ok
    logic div;         // word index estimate
    logic fix;         // word index correction, bit offset
    logic free_rd;     // read word holding the freed bit
    logic free_wr;     // write word with bit cleared, return ok
    logic emit_full;
    logic emit_range;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic idx_ok;
    logic hit;
    logic full;
  } dp_status_t;

endpackage

// ===== src/bitmap_first_free_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator: first-fit bitmap block allocator
// Grants the lowest free block below the count, or frees a given block.
// ----------------------------------------------------------------------------
//  port group   signals                             direction
//  request      start, busy, kind_i, block_index_i  in (busy out)
//  result       done_o, status_o, granted_index_o   out
//  config       cfg_we_i, cfg_wdata_i               in
//
//  Allocate: bitmap words are read one per cycle from the RAM, and each word is
//  searched in the cycle after its read; the scan ends on a grant or, past the
//  last word below the count, on "no free block". Free: index split, read,
//  write back; out of range: answered straight from idle. After reset the RAM is
//  cleared one word per cycle, all WORD_COUNT words (64 at defaults), with busy
//  high. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind_i,
  input  logic [bfa_pkg::IDX_W-1:0]    block_index_i,
  output logic                         done_o,
  output logic [bfa_pkg::STATUS_W-1:0] status_o,
  output logic [bfa_pkg::IDX_W-1:0]    granted_index_o,
  input  logic                         cfg_we_i,
  input  logic [bfa_pkg::CNT_W-1:0]    cfg_wdata_i
);
  import bfa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  bfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .st_i   (st),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  bfa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .block_index_i   (block_index_i),
    .cmd_i           (cmd),
    .st_o            (st),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_index_o (granted_index_o)
  );

  // a result word always comes with the block back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // failed requests and frees carry a zero index
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (granted_index_o == '0))
    else $error("nonzero index on failed request");

  // an accepted request either goes busy or answers at once
  a_accept_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request dropped");

endmodule

// ===== src/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfa_ctrl: allocator sequencer
// Runs the clearing pass, then steers each request through scan or free.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                kind_i,
  input  bfa_pkg::dp_status_t st_i,
  output bfa_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy
);
  import bfa_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_FIX   = 7'b0010000,
    S_RD    = 7'b0100000,
    S_WR    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (kind_i == KIND_ALLOC) begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end else if (st_i.idx_ok) begin
            cmd_o.load_idx = 1'b1;
            state_d        = S_DIV;
          end else begin
            cmd_o.emit_range = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (st_i.hit) begin
          cmd_o.alloc_wr = 1'b1;
          state_d        = S_IDLE;
        end else if (st_i.full) begin
          cmd_o.emit_full = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_RD;
      end
      S_RD: begin
        cmd_o.free_rd = 1'b1;
        state_d       = S_WR;
      end
      S_WR: begin
        cmd_o.free_wr = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== src/bfa_dp.sv =====
// ----------------------------------------------------------------------------
// bfa_dp: allocator datapath
// Count register, bitmap RAM, word scan with lowest-free search, index split
// for frees, and the result register.
// ----------------------------------------------------------------------------
module bfa_dp #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bfa_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic [bfa_pkg::IDX_W-1:0]    block_index_i,
  input  bfa_pkg::ctrl_cmd_t           cmd_i,
  output bfa_pkg::dp_status_t          st_o,
  output logic                         done_o,
  output logic [bfa_pkg::STATUS_W-1:0] status_o,
  output logic [bfa_pkg::IDX_W-1:0]    granted_index_o
);
  import bfa_pkg::*;

  localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PW         = $clog2(WORD_BITS);
  localparam int LIM_CAP    = (MAX_BLOCKS < INDEX_SPAN) ? MAX_BLOCKS : INDEX_SPAN;
  // index / WORD_BITS by reciprocal; estimate is exact or one low
  localparam int DIV_SH     = 20;
  localparam int RECIP_W    = DIV_SH - 2;
  localparam int PROD_W     = IDX_W + RECIP_W;
  localparam int QW         = PROD_W - DIV_SH;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << DIV_SH) / WORD_BITS);

  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     lim;
  logic [AW-1:0]        clr_q;
  logic [CNT_W-1:0]     iss_base_q, ev_base_q;
  logic [AW-1:0]        iss_w_q, ev_w_q;
  logic                 ev_vld_q;
  logic                 iss_more;
  logic [IDX_W-1:0]     idx_q;
  logic [QW-1:0]        q_est_q;
  logic [PROD_W-1:0]    prod;
  logic [IDX_W-1:0]     qmul, r_est;
  logic [AW-1:0]        fw_q;
  logic [PW-1:0]        fb_q;
  logic [CNT_W-1:0]     rem;
  logic [WORD_BITS-1:0] rdata, avail, first_free;
  logic [PW-1:0]        pos;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 done_q;
  logic [STATUS_W-1:0]  status_q;
  logic [IDX_W-1:0]     granted_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign lim = (count_q > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : count_q;

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // word scan: read issue one stage ahead of evaluation
  assign iss_more = (iss_base_q < lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_base_q <= '0;
      iss_w_q    <= '0;
      ev_base_q  <= '0;
      ev_w_q     <= '0;
      ev_vld_q   <= 1'b0;
    end else if (cmd_i.scan_init) begin
      iss_base_q <= '0;
      iss_w_q    <= '0;
      ev_vld_q   <= 1'b0;
    end else if (cmd_i.scan_step) begin
      ev_vld_q <= iss_more;
      if (iss_more) begin
        ev_base_q  <= iss_base_q;
        ev_w_q     <= iss_w_q;
        iss_base_q <= iss_base_q + CNT_W'(WORD_BITS);
        iss_w_q    <= iss_w_q + AW'(1);
      end
    end
  end

  // free bits of the evaluated word that lie below the count
  assign rem = lim - ev_base_q;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = ~rdata[b] & (CNT_W'(b) < rem);
    end
  end

  assign first_free = avail & (~avail + WORD_BITS'(1));

  always_comb begin
    pos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (first_free[b]) pos = pos | PW'(b);
    end
  end

  // free index split into word and bit
  assign prod  = PROD_W'(idx_q) * PROD_W'(RECIP);
  assign qmul  = IDX_W'(q_est_q) * IDX_W'(WORD_BITS);
  assign r_est = idx_q - qmul;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_idx) idx_q <= block_index_i;
    if (cmd_i.div) q_est_q <= prod[PROD_W-1:DIV_SH];
    if (cmd_i.fix) begin
      if (r_est >= IDX_W'(WORD_BITS)) begin
        fw_q <= AW'(q_est_q + QW'(1));
        fb_q <= PW'(r_est - IDX_W'(WORD_BITS));
      end else begin
        fw_q <= AW'(q_est_q);
        fb_q <= PW'(r_est);
      end
    end
  end

  // bitmap memory ports
  assign ram_re    = (cmd_i.scan_step & iss_more) | cmd_i.free_rd;
  assign ram_raddr = cmd_i.free_rd ? fw_q : iss_w_q;
  assign ram_we    = cmd_i.clr | cmd_i.alloc_wr | cmd_i.free_wr;

  always_comb begin
    priority if (cmd_i.clr) begin
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.free_wr) begin
      ram_waddr = fw_q;
      ram_wdata = rdata & ~(WORD_BITS'(1) << fb_q);
    end else begin
      ram_waddr = ev_w_q;
      ram_wdata = rdata | first_free;
    end
  end

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.alloc_wr | cmd_i.free_wr | cmd_i.emit_full | cmd_i.emit_range;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.alloc_wr) begin
      status_q  <= ST_OK;
      granted_q <= IDX_W'(ev_base_q + CNT_W'(pos));
    end else if (cmd_i.free_wr) begin
      status_q  <= ST_OK;
      granted_q <= '0;
    end else if (cmd_i.emit_full) begin
      status_q  <= ST_FULL;
      granted_q <= '0;
    end else if (cmd_i.emit_range) begin
      status_q  <= ST_RANGE;
      granted_q <= '0;
    end
  end

  assign st_o.clr_last = (clr_q == AW'(WORD_COUNT - 1));
  assign st_o.idx_ok   = (CNT_W'(block_index_i) < lim);
  assign st_o.hit      = ev_vld_q & (|avail);
  assign st_o.full     = ~ev_vld_q & ~iss_more;

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign granted_index_o = granted_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bitmap first-free allocator
// Streams allocate and free words into the block and mirrors the bitmap
// bit by bit. Each strobed result is checked in order against the mirror.
// The count register is swept over zero, one, word edges, full span and oversize.
// ----------------------------------------------------------------------------
module tb;
  import bfa_pkg::*;

  localparam int MAP_BITS = 4096;

  typedef struct {
    logic             kind;
    logic [IDX_W-1:0] index;
  } request_t;

  typedef struct {
    logic             kind;
    status_e          status;
    logic [IDX_W-1:0] granted;
  } grant_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic                busy;
  logic                kind_i        = KIND_ALLOC;
  logic [IDX_W-1:0]    block_index_i = '0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [IDX_W-1:0]    granted_index_o;
  logic                cfg_we_i      = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata_i   = '0;

  request_t            request_q[$];
  grant_t              grant_q[$];
  logic [MAP_BITS-1:0] used_map    = '0;
  logic [CNT_W-1:0]    count_model = COUNT_RESET;

  int n_queued   = 0;
  int n_accepted = 0;
  int n_driven   = 0;
  int n_errors   = 0;
  int n_grant    = 0;
  int n_full     = 0;
  int n_range    = 0;
  int n_freed    = 0;
  int n_settings = 0;
  int alloc_span = 0;
  int calm_lo    = 300;
  int calm_hi    = 420;
  bit accepted_now = 1'b0;

  bitmap_first_free_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .block_index_i   (block_index_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // effective limit: count clipped to the 12-bit index span
  function automatic int count_limit(logic [CNT_W-1:0] count);
    return (count > INDEX_SPAN) ? INDEX_SPAN : int'(count);
  endfunction

  function automatic grant_t predict_grant(logic kind, logic [IDX_W-1:0] idx);
    grant_t g;
    int     lim;
    g.kind    = kind;
    g.status  = ST_OK;
    g.granted = '0;
    lim       = count_limit(count_model);
    if (kind == KIND_ALLOC) begin
      g.status = ST_FULL;
      for (int i = 0; i < lim; i++) begin
        if (!used_map[i]) begin
          used_map[i] = 1'b1;
          g.status    = ST_OK;
          g.granted   = IDX_W'(i);
          break;
        end
      end
    end else if (int'(idx) >= lim) begin
      g.status = ST_RANGE;
    end else begin
      used_map[idx] = 1'b0;
    end
    return g;
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic queue_request(logic kind, logic [IDX_W-1:0] idx);
    request_t req;
    req.kind  = kind;
    req.index = idx;
    request_q.insert(request_q.size(), req);
    n_queued++;
  endtask

  // all words accepted, all results back, block not busy
  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((n_accepted != n_queued || grant_q.size() != 0 || busy !== 1'b0)
           && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  task automatic set_block_count(logic [CNT_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    count_model = value;
    n_settings++;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(logic [CNT_W-1:0] count, int n);
    int lim;
    int hi;
    int r;
    int v;
    set_block_count(count);
    lim = count_limit(count);
    for (int k = 0; k < n; k++) begin
      r  = $urandom_range(0, 99);
      hi = (alloc_span < lim) ? alloc_span : lim;
      if (r < 55) begin
        queue_request(KIND_ALLOC, IDX_W'($urandom));
        alloc_span++;
      end else if (r < 85) begin
        // free somewhere in the region that is likely occupied
        v = $urandom_range(0, hi + 1);
        queue_request(KIND_FREE, IDX_W'((v > 4095) ? 4095 : v));
      end else if (r < 93) begin
        v = lim - 1 + $urandom_range(0, 2);
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        queue_request(KIND_FREE, IDX_W'(v));
      end else begin
        queue_request(KIND_FREE, IDX_W'($urandom));
      end
    end
  endtask

  // driver: a word stays on the bus until the edge that takes it
  always @(negedge clk_i) begin : drive
    request_t req;
    bit       calm;
    if (!(start && !accepted_now)) begin
      accepted_now = 1'b0;
      calm = (n_driven >= calm_lo) && (n_driven < calm_hi);
      if (request_q.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
        req = request_q.pop_front();
        start         <= 1'b1;
        kind_i        <= req.kind;
        block_index_i <= req.index;
        n_driven++;
      end else begin
        start         <= 1'b0;
        kind_i        <= 1'($urandom_range(0, 1));
        block_index_i <= IDX_W'($urandom);
      end
    end
  end

  // monitor: check strobed results first, then record a newly taken word
  always @(posedge clk_i) begin : observe
    grant_t want;
    grant_t pred;
    if (rst_ni) begin
      if (done_o) begin
        if (grant_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: status=%0d granted=%0d",
                                    status_o, granted_index_o));
        end else begin
          want = grant_q.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status got %0d want %0d (kind %0d)",
                                      status_o, want.status, want.kind));
          if (granted_index_o !== want.granted)
            report_mismatch($sformatf("granted_index got %0d want %0d (kind %0d)",
                                      granted_index_o, want.granted, want.kind));
          case (want.status)
            ST_FULL:  n_full++;
            ST_RANGE: n_range++;
            default: begin
              if (want.kind == KIND_ALLOC) n_grant++;
              else n_freed++;
            end
          endcase
        end
      end
      if (start && !busy) begin
        pred = predict_grant(kind_i, block_index_i);
        grant_q.insert(grant_q.size(), pred);
        n_accepted++;
        accepted_now = 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[%0t] timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: full span, top index, freeing a free block
    set_block_count(COUNT_RESET);
    queue_request(KIND_ALLOC, '1);
    queue_request(KIND_ALLOC, '0);
    queue_request(KIND_ALLOC, 12'h5A5);
    queue_request(KIND_FREE,  12'd1);
    queue_request(KIND_ALLOC, '0);
    queue_request(KIND_FREE,  12'd5);
    queue_request(KIND_FREE,  12'd4095);
    queue_request(KIND_FREE,  12'd0);
    queue_request(KIND_ALLOC, '0);

    // zero count: nothing to grant, every index out of range
    set_block_count('0);
    queue_request(KIND_ALLOC, '0);
    queue_request(KIND_FREE,  12'd0);
    queue_request(KIND_FREE,  12'd4095);

    // count lowered to one: bits 1 and 2 stay set above the limit
    set_block_count(13'd1);
    queue_request(KIND_ALLOC, '0);
    queue_request(KIND_FREE,  12'd1);
    queue_request(KIND_FREE,  12'd0);
    queue_request(KIND_ALLOC, '0);
    queue_request(KIND_ALLOC, '0);

    // oversize count clips to the index span
    set_block_count(13'h1FFF);
    queue_request(KIND_FREE,  12'd4095);
    queue_request(KIND_ALLOC, '0);
    queue_request(KIND_FREE,  12'd2);
    queue_request(KIND_ALLOC, '0);

    random_phase(13'd64, 65);
    random_phase(13'd3, 65);
    random_phase(13'd65, 65);
    random_phase(COUNT_RESET, 65);
    random_phase(13'd1, 65);
    random_phase(13'd128, 65);
    random_phase(13'h1FFF, 65);
    random_phase(13'd63, 65);
    random_phase(13'd200, 65);
    random_phase(13'd5000, 65);
    random_phase(CNT_W'($urandom_range(1, 4096)), 65);
    random_phase(CNT_W'($urandom_range(0, 8191)), 65);
    random_phase(COUNT_RESET, 65);

    wait_drained();
    repeat (80) @(posedge clk_i);
    if (grant_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", grant_q.size()));

    $display("%0d words over %0d count settings: %0d grants, %0d frees",
             n_accepted, n_settings, n_grant, n_freed);
    $display("%0d no-free-block and %0d out-of-range results, %0d mismatches",
             n_full, n_range, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
